### rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared widths, result status codes, sequencer states and remainder unit phases.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Width of one stored key and of the reported slot field.
  localparam int unsigned KeyW       = 34;
  localparam int unsigned SlotFieldW = 4;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_ZERO_KEY  = 3'd5
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_HOME_WAIT,
    S_HOME_CHK,
    S_OCC_WAIT,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_FINISH
  } state_e;

  // Remainder unit phases.
  typedef enum logic [1:0] {
    MP_FOLD,
    MP_SCALE,
    MP_REDUCE
  } mod_phase_e;

endpackage

### rtl/lpht_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lpht_mod_unit.sv
// ----------------------------------------------------------------------------
// Key remainder unit
// Computes key mod SLOTS in fold, scale and reduce phases: the key is folded into
// a short value by chunk residues, then reduced by reciprocal multiplication.
// ----------------------------------------------------------------------------
module lpht_mod_unit import lpht_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [KeyW-1:0]          value_i,
  output logic                     busy_o,
  output logic [$clog2(SLOTS)-1:0] rem_o
);

  localparam int unsigned SlotW  = $clog2(SLOTS);
  localparam int unsigned ChunkW = 12;
  localparam int unsigned FoldW  = 24;
  localparam int unsigned RecipW = FoldW + 1;
  localparam int unsigned ProdW  = FoldW + RecipW;
  localparam int unsigned ShiftC = FoldW + SlotW;

  // Residues of the chunk weights and the rounded-up reciprocal of SLOTS.
  localparam logic [FoldW-1:0]  Res12C     = FoldW'((64'd1 << ChunkW) % 64'(SLOTS));
  localparam logic [FoldW-1:0]  Res24C     = FoldW'((64'd1 << (2 * ChunkW)) % 64'(SLOTS));
  localparam logic [FoldW-1:0]  SlotsC     = FoldW'(SLOTS);
  localparam logic [63:0]       RecipWideC = ((64'd1 << ShiftC) + 64'(SLOTS) - 64'd1)
                                             / 64'(SLOTS);
  localparam logic [RecipW-1:0] RecipC     = RecipW'(RecipWideC);

  logic              busy_q, busy_d;
  mod_phase_e        phase_q, phase_d;
  logic [KeyW-1:0]   val_q, val_d;
  logic [FoldW-1:0]  fold_q, fold_d;
  logic [FoldW-1:0]  quot_q, quot_d;
  logic [SlotW-1:0]  rem_q, rem_d;
  logic [FoldW-1:0]  fold_sum;
  logic [ProdW-1:0]  product;
  logic [FoldW-1:0]  remainder_wide;

  // Fold, scale by the reciprocal, then subtract the quotient multiple.
  always_comb begin
    fold_sum       = FoldW'(val_q[KeyW-1:2*ChunkW]) * Res24C
                   + FoldW'(val_q[2*ChunkW-1:ChunkW]) * Res12C
                   + FoldW'(val_q[ChunkW-1:0]);
    product        = ProdW'(fold_q) * ProdW'(RecipC);
    remainder_wide = fold_q - quot_q * SlotsC;
    busy_d  = busy_q;
    phase_d = phase_q;
    val_d   = val_q;
    fold_d  = fold_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = MP_FOLD;
      val_d   = value_i;
    end else if (busy_q) begin
      case (phase_q)
        MP_FOLD: begin
          fold_d  = fold_sum;
          phase_d = MP_SCALE;
        end
        MP_SCALE: begin
          quot_d  = FoldW'(product >> ShiftC);
          phase_d = MP_REDUCE;
        end
        MP_REDUCE: begin
          rem_d   = remainder_wide[SlotW-1:0];
          phase_d = MP_FOLD;
          busy_d  = 1'b0;
        end
        default: begin
          phase_d = MP_FOLD;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= MP_FOLD;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    fold_q <= fold_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

### rtl/linear_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// Linear probe hash table unit
// Open-addressed key table with linear probing and optional displacement.
// ----------------------------------------------------------------------------
// A zero key is answered without a table scan. A search, a duplicate or a full
// table scans every slot, one table read per cycle; an insert also reads its home
// slot and probes onward from it, checking the occupant first when displacement
// is on and the home slot is taken. The result beat appears in the same cycle
// that the block is ready again; a stalled result beat holds the sequencer. After
// reset a clearing pass empties the table before the first item.
module linear_probe_hash_table_unit import lpht_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_data_i,
  // Request channel.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  mode_i,
  input  logic [KeyW-1:0]       key_i,
  // Result channel.
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            status_o,
  output logic [SlotFieldW-1:0] slot_o
);

  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(SLOTS - 1);

  // Wrapping increment of a slot number.
  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s);
    return (s == LastSlot) ? '0 : s + 1'b1;
  endfunction

  state_e                state_q, state_d;
  logic [SlotW-1:0]      idx_q, idx_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [SlotW-1:0]      chk_idx_q, chk_idx_d;
  logic                  found_q, found_d;
  logic [SlotW-1:0]      found_slot_q, found_slot_d;
  logic                  empty_q, empty_d;
  logic                  displaced_q, displaced_d;
  logic                  disp_en_q;
  logic                  mode_q, mode_d;
  logic [KeyW-1:0]       key_q, key_d;
  logic [SlotW-1:0]      home_q, home_d;
  logic [KeyW-1:0]       carry_q, carry_d;
  status_e               pend_status_q, pend_status_d;
  logic [SlotW-1:0]      pend_slot_q, pend_slot_d;
  logic                  out_valid_q, out_valid_d;
  status_e               status_q, status_d;
  logic [SlotFieldW-1:0] slot_q, slot_d;
  logic [SlotW+SlotFieldW-1:0] slot_wide;

  logic                  ram_we;
  logic [SlotW-1:0]      ram_waddr;
  logic [KeyW-1:0]       ram_wdata;
  logic                  ram_re;
  logic [SlotW-1:0]      ram_raddr;
  logic [KeyW-1:0]       ram_rdata;

  logic                  mod_start;
  logic [KeyW-1:0]       mod_value;
  logic                  mod_busy;
  logic [SlotW-1:0]      mod_rem;

  // Key store.
  lpht_ram #(
    .Width (KeyW),
    .Depth (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared remainder unit for the home slot of the new key and of an occupant.
  lpht_mod_unit #(
    .SLOTS (SLOTS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (mod_value),
    .busy_o  (mod_busy),
    .rem_o   (mod_rem)
  );

  // The slot field carries the low bits of the slot number.
  assign slot_wide = {{SlotFieldW{1'b0}}, pend_slot_q};

  // Sequencer: next state, memory control and result capture.
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    chk_vld_d     = 1'b0;
    chk_idx_d     = idx_q;
    found_d       = found_q;
    found_slot_d  = found_slot_q;
    empty_d       = empty_q;
    displaced_d   = displaced_q;
    mode_d        = mode_q;
    key_d         = key_q;
    home_d        = home_q;
    carry_d       = carry_q;
    pend_status_d = pend_status_q;
    pend_slot_d   = pend_slot_q;
    out_valid_d   = out_valid_q;
    status_d      = status_q;
    slot_d        = slot_q;
    ram_we        = 1'b0;
    ram_waddr     = idx_q;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = idx_q;
    mod_start     = 1'b0;
    mod_value     = key_i;
    in_ready_o    = 1'b0;

    // Compare the entry read in the previous scan cycle.
    if (chk_vld_q) begin
      if (ram_rdata == key_q && !found_q) begin
        found_d      = 1'b1;
        found_slot_d = chk_idx_q;
      end
      if (ram_rdata == '0) begin
        empty_d = 1'b1;
      end
    end

    // The output register frees up when its beat is taken.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = '0;
        if (idx_q == LastSlot) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d      = mode_i;
          key_d       = key_i;
          found_d     = 1'b0;
          empty_d     = 1'b0;
          displaced_d = 1'b0;
          idx_d       = '0;
          if (key_i == '0) begin
            pend_status_d = ST_ZERO_KEY;
            pend_slot_d   = '0;
            state_d       = S_FINISH;
          end else begin
            mod_start = 1'b1;
            mod_value = key_i;
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
        chk_vld_d = 1'b1;
        chk_idx_d = idx_q;
        if (idx_q == LastSlot) begin
          state_d = S_SCAN_END;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SCAN_END: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        pend_slot_d = '0;
        state_d     = S_FINISH;
        if (mode_q) begin
          if (found_q) begin
            pend_status_d = ST_FOUND;
            pend_slot_d   = found_slot_q;
          end else begin
            pend_status_d = ST_NOT_FOUND;
          end
        end else if (found_q) begin
          pend_status_d = ST_DUPLICATE;
        end else if (!empty_q) begin
          pend_status_d = ST_FULL;
        end else begin
          state_d = S_HOME_WAIT;
        end
      end
      S_HOME_WAIT: begin
        if (!mod_busy) begin
          home_d    = mod_rem;
          ram_re    = 1'b1;
          ram_raddr = mod_rem;
          state_d   = S_HOME_CHK;
        end
      end
      S_HOME_CHK: begin
        if (ram_rdata == '0) begin
          ram_we        = 1'b1;
          ram_waddr     = home_q;
          ram_wdata     = key_q;
          pend_status_d = ST_INSERTED;
          pend_slot_d   = home_q;
          state_d       = S_FINISH;
        end else if (disp_en_q) begin
          carry_d   = ram_rdata;
          mod_start = 1'b1;
          mod_value = ram_rdata;
          state_d   = S_OCC_WAIT;
        end else begin
          carry_d = key_q;
          idx_d   = next_slot(home_q);
          state_d = S_PROBE_RD;
        end
      end
      S_OCC_WAIT: begin
        if (!mod_busy) begin
          // Evict an occupant that lives away from its own home slot.
          if (mod_rem != home_q) begin
            ram_we      = 1'b1;
            ram_waddr   = home_q;
            ram_wdata   = key_q;
            displaced_d = 1'b1;
          end else begin
            carry_d = key_q;
          end
          idx_d   = next_slot(home_q);
          state_d = S_PROBE_RD;
        end
      end
      S_PROBE_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
        state_d   = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (ram_rdata == '0) begin
          ram_we        = 1'b1;
          ram_waddr     = idx_q;
          ram_wdata     = carry_q;
          pend_status_d = ST_INSERTED;
          pend_slot_d   = displaced_q ? home_q : idx_q;
          state_d       = S_FINISH;
        end else begin
          idx_d   = next_slot(idx_q);
          state_d = S_PROBE_RD;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = pend_status_q;
          slot_d      = slot_wide[SlotFieldW-1:0];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      chk_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      empty_q     <= 1'b0;
      displaced_q <= 1'b0;
      out_valid_q <= 1'b0;
      disp_en_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      chk_vld_q   <= chk_vld_d;
      found_q     <= found_d;
      empty_q     <= empty_d;
      displaced_q <= displaced_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        disp_en_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    chk_idx_q     <= chk_idx_d;
    found_slot_q  <= found_slot_d;
    mode_q        <= mode_d;
    key_q         <= key_d;
    home_q        <= home_d;
    carry_q       <= carry_d;
    pend_status_q <= pend_status_d;
    pend_slot_q   <= pend_slot_d;
    status_q      <= status_d;
    slot_q        <= slot_d;
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;

  // The table is only written while an item is in work or being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_FINISH) |-> !ram_we)
    else $error("table written outside of an operation");

  // Only an insert or a find reports a nonzero slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_INSERTED && status_o != ST_FOUND) |-> slot_o == '0)
    else $error("nonzero slot reported with a failure status");

  // Probing starts only once the remainder unit has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE_RD || state_q == S_HOME_CHK) |-> !mod_busy)
    else $error("probe started while the home slot is still being computed");

  // A new result is loaded only into a free or draining output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_valid_q && !out_ready_i) |=> state_q == S_FINISH)
    else $error("result left the sequencer while the output was blocked");

endmodule
